// ----- rtl/servo_status_frame_parser_core_macros.svh -----
// Assertion macros for the servo status frame parser checker.
`ifndef SERVO_STATUS_FRAME_PARSER_CORE_MACROS_SVH
`define SERVO_STATUS_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define SSPF_ASSERT_SAME(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("sspf check failed");

// Next-cycle implication, disabled while dis is high.
`define SSPF_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("sspf check failed");

`endif

// ----- rtl/sspf_pkg.sv -----
// Shared constants for the servo status frame parser.
package sspf_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 16;
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam int BYTE_W = 8;
    localparam int POS_W = 4;
    localparam int M_FIELDS_W = 3 * BYTE_W + 1 + POS_W + BYTE_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int PRESENT_BIT = 3 * BYTE_W;

endpackage

// ----- rtl/servo_status_frame_parser_core.sv -----
// Servo status frame parser: byte-stream hunter, checksum and payload readout.
// Throughput: one input byte per cycle while parsing; s_tready drops during readout.
// Latency: the first result is valid in the cycle right after the checksum byte transfer.
// Readout: one result per cycle under m_tready, one stored byte read per cycle from the
//   payload memory port; a good frame of n payload bytes gives max(n, 1) results and holds
//   input until the last of them is taken, however long m_tready stalls a pending result.
// Reset (aresetn low, synchronous): hunt for the first 0xFF, no result pending.
module servo_status_frame_parser_core #(
    parameter int PAYLOAD_DEPTH = sspf_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] sender_id, [15:8] length_byte, [23:16] error_byte, [24] payload_present,
    // [28:25] payload_position, [36:29] payload_data, upper bits zero
    output logic [sspf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast   // last
);

    // Address width of the payload memory and width of the fill count.
    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
    localparam int PAD_W = sspf_pkg::M_TDATA_W - sspf_pkg::M_FIELDS_W;
    localparam logic [8:0] DEPTH_9 = 9'(PAYLOAD_DEPTH);

    // Parse phases, plus the readout phase that holds the input side.
    typedef enum logic [2:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_ID,
        ST_LEN,
        ST_ERR,
        ST_DATA,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [7:0] frame_id_reg, frame_id_next;
    logic [7:0] frame_len_reg, frame_len_next;
    logic [7:0] frame_err_reg, frame_err_next;
    logic [7:0] sum_reg, sum_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0] k_reg, k_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic present_reg, present_next;
    logic [sspf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0] data_reg, data_next;
    logic last_reg, last_next;

    // Payload memory: one write port, one registered read port.
    logic [7:0] payload_mem [PAYLOAD_DEPTH];
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic mem_re;
    logic [AW-1:0] mem_raddr;

    logic in_fire;
    logic [7:0] rx_byte;
    logic [7:0] n_len;
    logic [7:0] add_a;
    logic [7:0] add_sum;
    logic [7:0] k_inc;
    logic [CW-1:0] count_inc;
    logic overflow;

    assign rx_byte  = s_tdata;
    assign s_tready = (state_reg != ST_EMIT);
    assign in_fire  = s_tvalid && s_tready;

    // Payload length: length byte minus two, or none below two.
    assign n_len = (frame_len_reg < 8'd2) ? 8'd0 : (frame_len_reg - 8'd2);

    // Shared checksum adder; the id byte restarts the sum.
    assign add_a   = (state_reg == ST_ID) ? 8'd0 : sum_reg;
    assign add_sum = add_a + rx_byte;

    assign k_inc     = k_reg + 8'd1;
    assign count_inc = count_reg + CW'(1);
    assign overflow  = ({1'b0, n_len} > DEPTH_9) || (9'(count_reg) >= DEPTH_9);

    always_comb begin
        state_next     = state_reg;
        frame_id_next  = frame_id_reg;
        frame_len_next = frame_len_reg;
        frame_err_next = frame_err_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        m_tvalid_next  = m_tvalid_reg;
        present_next   = present_reg;
        pos_next       = pos_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_re         = 1'b0;
        mem_raddr      = '0;
        case (state_reg)
            ST_SYNC2: begin
                if (in_fire) begin
                    count_next = '0;
                    state_next = (rx_byte == sspf_pkg::SYNC_BYTE) ? ST_ID : ST_SYNC1;
                end
            end
            ST_ID: begin
                if (in_fire) begin
                    frame_id_next = rx_byte;
                    sum_next      = add_sum;
                    state_next    = ST_LEN;
                end
            end
            ST_LEN: begin
                if (in_fire) begin
                    frame_len_next = rx_byte;
                    sum_next       = add_sum;
                    state_next     = ST_ERR;
                end
            end
            ST_ERR: begin
                if (in_fire) begin
                    frame_err_next = rx_byte;
                    sum_next       = add_sum;
                    state_next     = (n_len == 8'd0) ? ST_CHECK : ST_DATA;
                end
            end
            ST_DATA: begin
                if (in_fire) begin
                    if (overflow) begin
                        // Drop a frame that cannot fit the buffer.
                        state_next = ST_SYNC1;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                        sum_next   = add_sum;
                        if (9'(count_inc) >= {1'b0, n_len}) begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (in_fire) begin
                    state_next = ST_SYNC1;
                    if (rx_byte == ~sum_reg) begin
                        m_tvalid_next = 1'b1;
                        k_next        = 8'd0;
                        pos_next      = '0;
                        if (n_len == 8'd0) begin
                            // Empty payload: one result with no data.
                            present_next = 1'b0;
                            data_next    = 8'd0;
                            last_next    = 1'b1;
                        end else begin
                            mem_re       = 1'b1;
                            present_next = 1'b1;
                            last_next    = (n_len == 8'd1);
                            state_next   = ST_EMIT;
                        end
                        if (n_len != 8'd0) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        m_tvalid_next = 1'b0;
                        state_next    = ST_SYNC1;
                    end else begin
                        // Advance to the next stored byte.
                        mem_re    = 1'b1;
                        mem_raddr = k_inc[AW-1:0];
                        k_next    = k_inc;
                        pos_next  = k_inc[sspf_pkg::POS_W-1:0];
                        last_next = ((k_inc + 8'd1) == n_len);
                    end
                end
            end
            default: begin
                // Hunt for the first sync byte.
                if (in_fire) begin
                    state_next = (rx_byte == sspf_pkg::SYNC_BYTE) ? ST_SYNC2 : ST_SYNC1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        present_reg   <= present_next;
        pos_reg       <= pos_next;
        last_reg      <= last_next;
        // Registered read of the payload memory feeds the output data directly.
        data_reg      <= mem_re ? payload_mem[mem_raddr] : data_next;
        if (!aresetn) begin
            state_reg     <= ST_SYNC1;
            m_tvalid_reg  <= 1'b0;
            frame_id_reg  <= '0;
            frame_len_reg <= '0;
            frame_err_reg <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            frame_id_reg  <= frame_id_next;
            frame_len_reg <= frame_len_next;
            frame_err_reg <= frame_err_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            payload_mem[mem_waddr] <= rx_byte;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, data_reg, pos_reg, present_reg,
                       frame_err_reg, frame_len_reg, frame_id_reg};

endmodule

// ----- rtl/sspf_checker.sv -----
// Port-level checker for the servo status frame parser, bound to the top level.
`include "servo_status_frame_parser_core_macros.svh"

module sspf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sspf_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // A stalled result holds its content.
    `SSPF_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Input is held off while a result is pending.
    `SSPF_ASSERT_SAME(a_no_input_during_readout, aclk, !aresetn, m_tvalid, !s_tready)

    // Reset leaves no result pending.
    `SSPF_ASSERT_NEXT(a_reset_clears_out, aclk, 1'b0, !aresetn, !m_tvalid)

    // A result without payload is the single, final result of an empty frame.
    `SSPF_ASSERT_SAME(a_empty_result_form, aclk, !aresetn, m_tvalid && !m_tdata[sspf_pkg::PRESENT_BIT], m_tlast && (m_tdata[sspf_pkg::M_TDATA_W-1:sspf_pkg::PRESENT_BIT] == '0))

endmodule

bind servo_status_frame_parser_core sspf_checker u_sspf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
